// ===== rtl/time_ordered_job_queue_defines.svh =====
// Assertion macros shared by the time-ordered job queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TIME_ORDERED_JOB_QUEUE_DEFINES_SVH
`define TIME_ORDERED_JOB_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define TOJQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication.
`define TOJQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TOJQ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TOJQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tojq_pkg.sv =====
// Shared types and constants of the time-ordered job queue.
// Depends on nothing; used by the interfaces, the cell and the top level.
package tojq_pkg;

   localparam int CMD_W    = 2;
   localparam int JOB_W    = 16;
   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 16;
   localparam int STAT_W   = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_FIND   = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic [JOB_W-1:0]    job_number;
      logic [TIME_W-1:0]   start_time;
      logic [HANDLE_W-1:0] file_handle;
   } entry_type;

   // Broadcast from the top level to every cell of the chain.
   typedef struct packed {
      cell_op_type      op;
      entry_type        new_entry;
      logic [JOB_W-1:0] key_job;
   } cell_ctl_type;

endpackage

// ===== rtl/tojq_if.sv =====
// Valid/ready channel interfaces for commands and results of the job queue.
// Depends on tojq_pkg for the field widths.
interface tojq_req_if import tojq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [JOB_W-1:0]    job_number;
   logic [TIME_W-1:0]   start_time;
   logic [HANDLE_W-1:0] file_handle;

   modport source (output valid, command, job_number, start_time, file_handle,
                   input ready);
   modport sink   (input valid, command, job_number, start_time, file_handle,
                   output ready);
endinterface

interface tojq_rsp_if import tojq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STAT_W-1:0]   status;
   logic [JOB_W-1:0]    out_job_number;
   logic [TIME_W-1:0]   out_start_time;
   logic [HANDLE_W-1:0] out_file_handle;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_job_number, out_start_time,
                   out_file_handle, occupancy, input ready);
   modport sink   (input valid, status, out_job_number, out_start_time,
                   out_file_handle, occupancy, output ready);
endinterface

// ===== rtl/time_ordered_job_queue.sv =====
// Time-ordered job queue: a chain of cells kept sorted by start time.
// Depends on tojq_pkg, the channel interfaces and tojq_cell.
//
// Usage: commands arrive on the req_ch channel (insert, pop earliest, find
// by job number) and every command yields exactly one result on rsp_ch.
// Each transfer happens at a rising edge where valid and ready are high.
// Insert and pop act on all cells at once: on an insert every cell compares
// its own start time with the new key, and all cells shift together, so the
// result of an insert, a pop or an unused command is presented in the cycle
// after its transfer; such commands are taken one per cycle unless rsp_ch stalls.
// Find walks the chain one slot per cycle from the earliest entry and stops at
// the matching slot or the last held one, where its result is loaded into the
// output register; a find on an empty queue presents its result in the cycle
// after its transfer. No command is taken during a walk.
// The result sits in an output register; a new command is taken only when
// that register is empty or is being drained in the same cycle, so a stalled
// receiver simply holds req_ch.ready low and nothing is lost.
// Reset clears the entry count and the control state; the slot contents are
// never read before they are written, so they are not cleared.
`include "time_ordered_job_queue_defines.svh"

module time_ordered_job_queue import tojq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   tojq_req_if.sink   req_ch,
   tojq_rsp_if.source rsp_ch
);

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int IdxW = $clog2(DEPTH);

   // The search walk is the only multi-cycle activity.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FIND = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [IdxW-1:0]  find_idx_ff, find_idx_in;
   logic [JOB_W-1:0] find_key_ff, find_key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   entry_type           rsp_entry_ff, rsp_entry_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic                rsp_load;

   cell_ctl_type        ctl;
   entry_type           entry_w [DEPTH];
   logic [DEPTH-1:0]    lt_w;
   logic [DEPTH-1:0]    match_w;

   logic fire;
   logic is_full;
   logic is_empty;
   logic find_hit;
   logic find_last;
   entry_type req_entry;

   // The output register is free when empty or when its result is
   // transferred in this same cycle.
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign fire         = req_ch.valid && req_ch.ready;
   assign is_full      = count_ff == CntW'(DEPTH);
   assign is_empty     = count_ff == '0;

   assign req_entry.job_number  = req_ch.job_number;
   assign req_entry.start_time  = req_ch.start_time;
   assign req_entry.file_handle = req_ch.file_handle;

   // Control broadcast to the chain.
   always_comb begin
      ctl.op        = CELL_HOLD;
      ctl.new_entry = req_entry;
      ctl.key_job   = find_key_ff;
      if (fire && (req_ch.command == CMD_INSERT) && !is_full) begin
         ctl.op = CELL_INSERT;
      end else if (fire && (req_ch.command == CMD_POP) && !is_empty) begin
         ctl.op = CELL_POP;
      end
   end

   // The chain itself. The slot before the first acts as an entry that is
   // earlier than any key, so an insert lands in slot zero when nothing
   // held is earlier.
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_type prev_entry;
      logic      prev_lt;
      entry_type next_entry;

      if (gi == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_lt    = 1'b1;
      end else begin : g_inner
         assign prev_entry = entry_w[gi-1];
         assign prev_lt    = lt_w[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_body
         assign next_entry = entry_w[gi+1];
      end

      tojq_cell #(
         .DEPTH (DEPTH),
         .INDEX (gi)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .next_entry (next_entry),
         .entry      (entry_w[gi]),
         .lt         (lt_w[gi]),
         .match      (match_w[gi])
      );
   end

   // The walk inspects one slot per cycle and stops at the first match or
   // at the last held entry.
   assign find_hit  = match_w[find_idx_ff];
   assign find_last = (CntW'(find_idx_ff) + CntW'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      find_idx_in   = find_idx_ff;
      find_key_in   = find_key_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_entry_in  = '0;
      rsp_occ_in    = OCC_W'(count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               case (req_ch.command)
                  CMD_INSERT: begin
                     rsp_load = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        count_in   = count_ff + CntW'(1);
                        rsp_occ_in = OCC_W'(count_in);
                     end
                  end
                  CMD_POP: begin
                     rsp_load = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        count_in     = count_ff - CntW'(1);
                        rsp_entry_in = entry_w[0];
                        rsp_occ_in   = OCC_W'(count_in);
                     end
                  end
                  CMD_FIND: begin
                     if (is_empty) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        find_key_in = req_ch.job_number;
                        find_idx_in = '0;
                        state_in    = ST_FIND;
                     end
                  end
                  default: begin
                     // The unused command code changes nothing.
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (find_hit || find_last) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (find_hit) begin
                  rsp_entry_in = entry_w[find_idx_ff];
               end else begin
                  rsp_status_in = STAT_NOT_FOUND;
               end
            end else begin
               find_idx_in = find_idx_ff + IdxW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      find_idx_ff <= find_idx_in;
      find_key_ff <= find_key_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.out_job_number  = rsp_entry_ff.job_number;
   assign rsp_ch.out_start_time  = rsp_entry_ff.start_time;
   assign rsp_ch.out_file_handle = rsp_entry_ff.file_handle;
   assign rsp_ch.occupancy       = rsp_occ_ff;

   // The entry count never passes the number of cells.
   `TOJQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(DEPTH))
   // During a walk the output register is always empty.
   `TOJQ_ASSERT_NOW(a_find_out_free, clock, reset, state_ff == ST_FIND, !rsp_valid_ff)
   // The walk stays within the held entries.
   `TOJQ_ASSERT_NOW(a_find_in_range, clock, reset, state_ff == ST_FIND,
                    CntW'(find_idx_ff) < count_ff)
   // An accepted insert into a queue with room grows it by one.
   `TOJQ_ASSERT_NEXT(a_insert_grows, clock, reset,
                     fire && (req_ch.command == CMD_INSERT) && !is_full,
                     count_ff == $past(count_ff) + CntW'(1))

endmodule

// ===== rtl/tojq_cell.sv =====
// One slot of the sorted job chain: holds an entry and shifts with neighbors.
// Depends on tojq_pkg for the entry and control types.
module tojq_cell import tojq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0,
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [CntW-1:0]   count,
   input  entry_type         prev_entry,
   input  logic              prev_lt,
   input  entry_type         next_entry,
   output entry_type         entry,
   output logic              lt,
   output logic              match
);

   entry_type entry_ff, entry_in;
   logic      occupied;

   assign occupied = count > CntW'(INDEX);
   assign lt       = occupied && (entry_ff.start_time < ctl.new_entry.start_time);
   assign match    = occupied && (entry_ff.job_number == ctl.key_job);
   assign entry    = entry_ff;

   // On insert, earlier slots keep their entry, the first slot not earlier takes the
   // new one and the rest take their left neighbor's; on pop all take the right one's.
   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (!lt) begin
               entry_in = prev_lt ? ctl.new_entry : prev_entry;
            end
         end
         CELL_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
